>>> sv/pf_pkg.sv
// Shared types and constants for the prime factorizer.
package pf_pkg;

    localparam int PRIME_W     = 31;
    localparam int EXP_W       = 5;
    localparam int MAX_RESULTS = 9;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);
    localparam logic [EXP_W-1:0] EXP_MAX = 5'd31;

    typedef struct packed {
        logic load;
        logic div_start;
        logic take_quot;
        logic next_d;
        logic emit;
        logic emit_sel_n;
        logic emit_zero;
        logic flush;
    } pf_cmd_t;

    typedef struct packed {
        logic n_lt2;
        logic n_gt1;
        logic div_done;
        logic d_gt_q;
        logic r_zero;
        logic out_free;
    } pf_sts_t;

endpackage

>>> sv/pf_div.sv
// Serial restoring divider, one quotient bit per cycle.
module pf_div #(
    parameter int W = 31
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         done,
    output logic         busy,
    output logic [W-1:0] quo,
    output logic [W-1:0] rem
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  rem_reg;
    logic [W:0]    trial;
    logic [W:0]    diff;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (!diff[W]) begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

>>> sv/pf_datapath.sv
// Datapath: value, divisor and exponent registers, pending and output words.
module pf_datapath import pf_pkg::*; #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pf_cmd_t                cmd,
    output pf_sts_t                sts,
    input  logic [VALUE_WIDTH-1:0] s_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PRIME_W-1:0]     m_prime,
    output logic [EXP_W-1:0]       m_exponent,
    output logic                   m_has_factor,
    output logic                   m_last
);

    localparam int VW = VALUE_WIDTH;
    localparam int EW = $clog2(VALUE_WIDTH + 1);

    logic [VW-1:0]      n_reg;
    logic [VW-1:0]      d_reg;
    logic [EW-1:0]      e_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic               pend_valid_reg;
    logic [PRIME_W-1:0] pend_prime_reg;
    logic [EXP_W-1:0]   pend_exp_reg;
    logic               m_valid_reg;
    logic [PRIME_W-1:0] m_prime_reg;
    logic [EXP_W-1:0]   m_exp_reg;
    logic               m_has_reg;
    logic               m_last_reg;

    logic               div_done;
    logic               div_busy;
    logic [VW-1:0]      div_quo;
    logic [VW-1:0]      div_rem;
    logic [VW-1:0]      new_src;
    logic [PRIME_W-1:0] new_prime;
    logic [EXP_W-1:0]   e_sat;
    logic [EXP_W-1:0]   new_exp;

    pf_div #(.W(VW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (n_reg),
        .den     (d_reg),
        .done    (div_done),
        .busy    (div_busy),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    assign new_src   = cmd.emit_sel_n ? n_reg : d_reg;
    assign new_prime = PRIME_W'(64'(new_src));
    assign e_sat     = (64'(e_reg) > 64'(EXP_MAX)) ? EXP_MAX : EXP_W'(64'(e_reg));
    assign new_exp   = cmd.emit_sel_n ? EXP_W'(1) : e_sat;

    always_comb begin
        sts.n_lt2    = (n_reg[VW-1:1] == '0);
        sts.n_gt1    = |n_reg[VW-1:1];
        sts.div_done = div_done;
        sts.d_gt_q   = (d_reg > div_quo);
        sts.r_zero   = (div_rem == '0);
        sts.out_free = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            n_reg <= s_value;
            d_reg <= VW'(2);
            e_reg <= '0;
        end else begin
            if (cmd.take_quot) begin
                n_reg <= div_quo;
                e_reg <= e_reg + EW'(1);
            end
            if (cmd.next_d) begin
                d_reg <= d_reg + VW'(1);
                e_reg <= '0;
            end
        end
        if (cmd.emit && cnt_reg < COUNT_W'(MAX_RESULTS)) begin
            pend_prime_reg <= new_prime;
            pend_exp_reg   <= new_exp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                cnt_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end else if (cmd.emit && cnt_reg < COUNT_W'(MAX_RESULTS)) begin
                cnt_reg        <= cnt_reg + COUNT_W'(1);
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.emit_zero || cmd.flush ||
                (cmd.emit && pend_valid_reg && cnt_reg < COUNT_W'(MAX_RESULTS))) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_zero) begin
            m_prime_reg <= '0;
            m_exp_reg   <= '0;
            m_has_reg   <= 1'b0;
            m_last_reg  <= 1'b1;
        end else if (cmd.flush ||
                     (cmd.emit && pend_valid_reg && cnt_reg < COUNT_W'(MAX_RESULTS))) begin
            m_prime_reg <= pend_prime_reg;
            m_exp_reg   <= pend_exp_reg;
            m_has_reg   <= 1'b1;
            m_last_reg  <= cmd.flush;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_prime      = m_prime_reg;
    assign m_exponent   = m_exp_reg;
    assign m_has_factor = m_has_reg;
    assign m_last       = m_last_reg;

    a_div_idle_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> div_rem < d_reg)
        else $error("remainder not below divisor");

    a_out_write_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_zero || cmd.flush || cmd.emit) |-> sts.out_free)
        else $error("output word overwritten before taken");

    a_flush_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.flush |-> pend_valid_reg)
        else $error("flush without pending factor");

endmodule

>>> sv/pf_ctrl.sv
// Controller: sequences trial division, factor emission and run flush.
module pf_ctrl import pf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  pf_sts_t sts,
    output pf_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DSTART,
        ST_DIV,
        ST_EVAL,
        ST_EMIT_D,
        ST_EMIT_N,
        ST_FLUSH
    } state_t;

    state_t state_reg, state_next;
    logic   inner_reg, inner_next;

    always_comb begin
        state_next = state_reg;
        inner_next = inner_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    inner_next = 1'b0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!sts.n_lt2) begin
                    state_next = ST_DSTART;
                end else if (sts.out_free) begin
                    cmd.emit_zero = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_DSTART: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (inner_reg) begin
                    if (sts.r_zero) begin
                        cmd.take_quot = 1'b1;
                        state_next    = ST_DSTART;
                    end else begin
                        state_next = ST_EMIT_D;
                    end
                end else if (sts.d_gt_q) begin
                    state_next = sts.n_gt1 ? ST_EMIT_N : ST_FLUSH;
                end else if (sts.r_zero) begin
                    cmd.take_quot = 1'b1;
                    inner_next    = 1'b1;
                    state_next    = ST_DSTART;
                end else begin
                    cmd.next_d = 1'b1;
                    state_next = ST_DSTART;
                end
            end
            ST_EMIT_D: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.next_d = 1'b1;
                    inner_next = 1'b0;
                    state_next = ST_DSTART;
                end
            end
            ST_EMIT_N: begin
                if (sts.out_free) begin
                    cmd.emit       = 1'b1;
                    cmd.emit_sel_n = 1'b1;
                    state_next     = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (sts.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            inner_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            inner_reg <= inner_next;
        end
    end

endmodule

>>> sv/prime_factorizer.sv
// Top level of the trial-division prime factorizer.
//
// Input channel s_valid/s_ready/s_value takes one word to factor. The result
// channel m_valid/m_ready carries one word per distinct prime in ascending
// order: m_prime, m_exponent, m_has_factor, with m_last on the final word of
// the run. Inputs 0 and 1 give one word with m_has_factor clear, m_last set.
// Each trial is one division of the working value by the current divisor in
// the serial restoring divider, and a run makes up to about sqrt(value) plus
// the multiplicities of such divisions. One value is worked at a time; s_ready
// is high only between runs. Results pass through a pending register and an
// output register, so a new value is taken while the last word of the
// previous run still waits. A stalled receiver holds the datapath until the
// output frees. Synchronous active-low reset returns to idle with no result
// valid; no clearing pass is needed.
module prime_factorizer import pf_pkg::*; #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_WIDTH-1:0] s_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [PRIME_W-1:0]     m_prime,
    output logic [EXP_W-1:0]       m_exponent,
    output logic                   m_has_factor,
    output logic                   m_last
);

    pf_cmd_t cmd;
    pf_sts_t sts;

    pf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pf_datapath #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_prime      (m_prime),
        .m_exponent   (m_exponent),
        .m_has_factor (m_has_factor),
        .m_last       (m_last)
    );

endmodule

>>> tb/factor_checker.sv
// Result checker for the prime factorizer: predicts each run of factor words and compares.
`timescale 1ns / 1ps

module factor_checker import pf_pkg::*; #(
    parameter int VALUE_W = 31
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [PRIME_W-1:0] m_prime,
    input  logic [EXP_W-1:0]   m_exponent,
    input  logic               m_has_factor,
    input  logic               m_last,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic [PRIME_W-1:0] prime;
        logic [EXP_W-1:0]   exponent;
        logic               has_factor;
        logic               last;
    } factor_word_t;

    factor_word_t expected_factors[$];

    task automatic predict_factors(input logic [VALUE_W-1:0] value);
        longint unsigned n;
        longint unsigned d;
        longint unsigned e;
        int count;
        factor_word_t run [MAX_RESULTS];
        factor_word_t w;
        n = 64'(value);
        count = 0;
        if (n < 2) begin
            w.prime = '0;
            w.exponent = '0;
            w.has_factor = 1'b0;
            w.last = 1'b1;
            expected_factors = {expected_factors, w};
            return;
        end
        for (d = 2; d <= n / d; d++) begin
            if (n % d == 0) begin
                e = 0;
                while (n % d == 0) begin
                    n = n / d;
                    e++;
                end
                if (count < MAX_RESULTS) begin
                    w.prime = d[PRIME_W-1:0];
                    w.exponent = (e > 64'(EXP_MAX)) ? EXP_MAX : e[EXP_W-1:0];
                    w.has_factor = 1'b1;
                    w.last = 1'b0;
                    run[count] = w;
                    count++;
                end
            end
        end
        if (n > 1 && count < MAX_RESULTS) begin
            w.prime = n[PRIME_W-1:0];
            w.exponent = EXP_W'(1);
            w.has_factor = 1'b1;
            w.last = 1'b0;
            run[count] = w;
            count++;
        end
        w = run[count-1];
        w.last = 1'b1;
        run[count-1] = w;
        for (int i = 0; i < count; i++) begin
            expected_factors = {expected_factors, run[i]};
        end
    endtask

    always @(posedge aclk) begin : check_words
        factor_word_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_factors.size() == 0) begin
                    $error("unexpected result word: prime %0d exponent %0d has_factor %0b last %0b",
                           m_prime, m_exponent, m_has_factor, m_last);
                    errors++;
                end else begin
                    want = expected_factors.pop_front();
                    if (m_prime !== want.prime) begin
                        $error("prime: expected %0d, actual %0d", want.prime, m_prime);
                        errors++;
                    end
                    if (m_exponent !== want.exponent) begin
                        $error("exponent: expected %0d, actual %0d", want.exponent, m_exponent);
                        errors++;
                    end
                    if (m_has_factor !== want.has_factor) begin
                        $error("has_factor: expected %0b, actual %0b", want.has_factor,
                               m_has_factor);
                        errors++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, m_last);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_factors(s_value);
            end
            pending <= expected_factors.size();
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the prime factorizer testbench: clock, reset, stimulus, ready stalls and verdict.
`timescale 1ns / 1ps

module testbench;
    import pf_pkg::*;

    localparam int VALUE_W      = 31;
    localparam int RANDOM_WORDS = 80;
    localparam int QUIET_WORDS  = 20;
    localparam int TRIAL_CAP    = 400;
    localparam int IDLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES = 64;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [PRIME_W-1:0] m_prime;
    logic [EXP_W-1:0]   m_exponent;
    logic               m_has_factor;
    logic               m_last;

    int   errors;
    int   pending;
    bit   quiet = 1'b0;
    int   stall_left = 0;
    int   calm_left = 0;
    int   idle_cycles = 0;

    prime_factorizer #(.VALUE_WIDTH(VALUE_W)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_prime      (m_prime),
        .m_exponent   (m_exponent),
        .m_has_factor (m_has_factor),
        .m_last       (m_last)
    );

    factor_checker #(.VALUE_W(VALUE_W)) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_prime      (m_prime),
        .m_exponent   (m_exponent),
        .m_has_factor (m_has_factor),
        .m_last       (m_last),
        .errors       (errors),
        .pending      (pending)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (quiet || calm_left > 0) begin
            m_ready <= 1'b1;
            if (calm_left > 0) calm_left--;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            case ($urandom_range(0, 15))
                0, 1, 2: stall_left = $urandom_range(1, 12);
                3:       calm_left = $urandom_range(20, 200);
                default: ;
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("prime_factorizer test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_value(input logic [VALUE_W-1:0] value);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        longint unsigned cand;
        longint unsigned n;
        longint unsigned d;
        longint unsigned f;
        int tries;
        int w;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_value(31'd0);
        send_value(31'd1);
        send_value(31'd2);
        send_value(31'd3);
        send_value(31'd4);
        send_value(31'd6);
        send_value(31'd12);
        send_value(31'd49);
        send_value(31'd97);
        send_value(31'd1429);
        send_value(31'd30030);
        send_value(31'd6220800);
        send_value(31'd1073741824);
        send_value(31'd1162261467);
        send_value(31'd223092870);
        send_value(31'd1073741823);
        send_value(31'd2147483646);
        send_value(31'd1073758208);
        send_value(31'd1000003);
        send_value(31'd65537);

        // hold off until the directed runs have drained
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS - QUIET_WORDS) quiet = 1'b1;
            do begin
                case ($urandom_range(0, 3))
                    0: begin
                        w = $urandom_range(1, VALUE_W);
                        cand = 64'($urandom) & ((64'd1 << w) - 1);
                    end
                    1: begin
                        cand = 1;
                        repeat ($urandom_range(1, 16)) begin
                            f = 64'($urandom_range(2, 97));
                            if (cand * f < (64'd1 << VALUE_W)) cand = cand * f;
                        end
                    end
                    2: cand = longint'($urandom_range(1, 1023)) << $urandom_range(0, VALUE_W - 10);
                    default: cand = 64'($urandom_range(2, 200000));
                endcase
                // drop values whose trial division would run too long
                n = cand;
                d = 2;
                tries = 0;
                while (d <= n / d && tries <= TRIAL_CAP) begin
                    while (n % d == 0) n = n / d;
                    d++;
                    tries++;
                end
            end while (tries > TRIAL_CAP);
            send_value(cand[VALUE_W-1:0]);
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("prime_factorizer test passed");
        end else begin
            $display("prime_factorizer test failed");
        end
        $finish;
    end

endmodule
